// ===== design/scl_pkg.sv =====
// scl_pkg: shared types and constants for the source code lexer.
// No dependencies.
package scl_pkg;

	localparam int LINE_BITS = 20;
	localparam int COLUMN_BITS = 16;
	localparam int LENGTH_BITS = 16;

	localparam int KIND_SINGLE_BASE = 19;
	localparam logic [5:0] KIND_IDENT = 6'd44;
	localparam logic [5:0] KIND_HEX = 6'd45;
	localparam logic [5:0] KIND_END = 6'd46;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_NO_LETTER = 3'd1;
	localparam logic [2:0] ERR_HEX_UNDERSCORE = 3'd2;
	localparam logic [2:0] ERR_OPEN_COMMENT = 3'd3;
	localparam logic [2:0] ERR_BAD_CHAR = 3'd4;
	localparam logic [2:0] ERR_DECIMAL = 3'd5;

	// lookup results meaning "not a symbol" / "not an operator"
	localparam logic [4:0] SYM_NONE = 5'd25;
	localparam logic [4:0] PAIR_NONE = 5'd19;

	typedef logic [LINE_BITS-1:0] line_t;
	typedef logic [COLUMN_BITS-1:0] col_t;
	typedef logic [LENGTH_BITS-1:0] len_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [5:0] token_kind;
		logic is_error;
		logic [2:0] error_code;
		line_t start_line;
		col_t start_column;
		len_t token_length;
		logic last_of_run;
	} out_item_t;

	// single-symbol index, SYM_NONE means none
	function automatic logic [4:0] single_index(input logic [7:0] c);
		case (c)
			"<": single_index = 5'd0;
			">": single_index = 5'd1;
			";": single_index = 5'd2;
			":": single_index = 5'd3;
			"+": single_index = 5'd4;
			"-": single_index = 5'd5;
			"*": single_index = 5'd6;
			",": single_index = 5'd7;
			"=": single_index = 5'd8;
			"#": single_index = 5'd9;
			"!": single_index = 5'd10;
			"/": single_index = 5'd11;
			"%": single_index = 5'd12;
			"(": single_index = 5'd13;
			")": single_index = 5'd14;
			"{": single_index = 5'd15;
			"}": single_index = 5'd16;
			".": single_index = 5'd17;
			"[": single_index = 5'd18;
			"]": single_index = 5'd19;
			"&": single_index = 5'd20;
			"|": single_index = 5'd21;
			"^": single_index = 5'd22;
			"?": single_index = 5'd23;
			"$": single_index = 5'd24;
			default: single_index = SYM_NONE;
		endcase
	endfunction

	// two-char operator index, PAIR_NONE means none
	function automatic logic [4:0] pair_index(input logic [7:0] a, input logic [7:0] b);
		pair_index = PAIR_NONE;
		if (b == "=") begin
			case (a)
				"<": pair_index = 5'd0;
				">": pair_index = 5'd1;
				"!": pair_index = 5'd2;
				"=": pair_index = 5'd3;
				"+": pair_index = 5'd11;
				"*": pair_index = 5'd12;
				"-": pair_index = 5'd13;
				"/": pair_index = 5'd14;
				"&": pair_index = 5'd15;
				"|": pair_index = 5'd16;
				"^": pair_index = 5'd17;
				"%": pair_index = 5'd18;
				default: pair_index = PAIR_NONE;
			endcase
		end else if (a == b) begin
			case (a)
				"<": pair_index = 5'd4;
				">": pair_index = 5'd5;
				"&": pair_index = 5'd6;
				"|": pair_index = 5'd7;
				"+": pair_index = 5'd9;
				"-": pair_index = 5'd10;
				default: pair_index = PAIR_NONE;
			endcase
		end else if (a == "-" && b == ">") begin
			pair_index = 5'd8;
		end
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = c >= "0" && c <= "9";
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = c == " " || c == 8'd10 || c == 8'd13 || c == 8'd9 || c == 8'd8
			|| c == 8'd11 || c == 8'd12;
	endfunction

endpackage

// ===== design/source_code_lexer.sv =====
// source_code_lexer: top level; scanner front end, result queue to port.
// Uses scl_pkg, scl_front, scl_queue.
//
// channel | handshake             | payload
// in      | in_valid / in_ready   | in_data  (scl_pkg::in_item_t)
// out     | out_valid / out_ready | out_data (scl_pkg::out_item_t)
//
// One byte per cycle while in_ready is high: scanner state loops each cycle.
// A byte makes at most three results; the queue (8 entries by default) accepts
// a byte while at least three entries are free, so bytes keep flowing while
// results wait. Results leave one per cycle, in order, while out_ready is high.
// Reset puts the scanner in its start state (line 1) and clears queue pointers.
module source_code_lexer #(
	parameter int QUEUE_DEPTH_LOG = 3
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input scl_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output scl_pkg::out_item_t out_data
);

	scl_pkg::out_item_t [2:0] items;
	logic [1:0] count;
	logic fire;

	assign fire = in_valid && in_ready;

	scl_front u_front (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .in_fire(fire),
		.items(items), .item_count(count)
	);

	scl_queue #(.DEPTH_LOG(QUEUE_DEPTH_LOG)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_items(items),
		.wr_count(fire ? count : 2'd0), .room(in_ready),
		.rd_item(out_data), .rd_valid(out_valid), .rd_ready(out_ready)
	);

	a_eot_token: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_data.end_of_text |-> count != 2'd0)
		else $error("end of text without end token");

endmodule

// ===== design/scl_front.sv =====
// scl_front: scanner state machine; classifies each byte and produces up to
// three result items per byte as one bundle. Uses scl_pkg.
module scl_front (
	input logic clk,
	input logic arst_n,
	input scl_pkg::in_item_t in_item,
	input logic in_fire,
	output scl_pkg::out_item_t [2:0] items,
	output logic [1:0] item_count
);

	typedef enum logic [3:0] {
		M_IDLE, M_SYM, M_IDENT, M_ZERO, M_HEX, M_DEC, M_LINE_CMT, M_BLOCK_CMT
	} mode_t;

	mode_t mode_q, mode_d;
	logic [7:0] held_q, held_d;
	scl_pkg::line_t line_q, line_d, tok_line_q, tok_line_d;
	scl_pkg::col_t col_q, col_d, tok_col_q, tok_col_d;
	scl_pkg::len_t len_q, len_d;
	logic letter_q, letter_d, hexdig_q, hexdig_d, star_q, star_d;

	logic [7:0] c;
	assign c = in_item.char_code;

	function automatic scl_pkg::out_item_t mk(input logic [5:0] kind, input logic [2:0] code,
			input scl_pkg::line_t ln, input scl_pkg::col_t cl,
			input scl_pkg::len_t ln2);
		scl_pkg::out_item_t o;
		o.token_kind = kind;
		o.is_error = code != scl_pkg::ERR_NONE;
		o.error_code = code;
		o.start_line = ln;
		o.start_column = cl;
		o.token_length = ln2;
		o.last_of_run = 1'b0;
		return o;
	endfunction

	always_comb begin
		scl_pkg::out_item_t [2:0] it;
		logic [1:0] n;
		logic fresh, fin;
		logic [4:0] si, pi;
		scl_pkg::len_t grown;
		it = '0;
		n = 2'd0;
		fresh = 1'b0;
		fin = 1'b0;
		mode_d = mode_q;
		held_d = held_q;
		tok_line_d = tok_line_q;
		tok_col_d = tok_col_q;
		len_d = len_q;
		letter_d = letter_q;
		hexdig_d = hexdig_q;
		star_d = star_q;
		grown = (&len_q) ? len_q : len_q + 1'b1;
		si = scl_pkg::single_index(held_q);
		pi = scl_pkg::pair_index(held_q, c);
		case (mode_q)
			M_SYM: begin
				if (held_q == "/" && c == "/") mode_d = M_LINE_CMT;
				else if (held_q == "/" && c == "*") begin
					mode_d = M_BLOCK_CMT;
					star_d = 1'b0;
				end else if (pi != scl_pkg::PAIR_NONE) begin
					it[0] = mk(6'(pi), scl_pkg::ERR_NONE, tok_line_q, tok_col_q,
						scl_pkg::len_t'(2));
					n = 2'd1;
					mode_d = M_IDLE;
				end else begin
					it[0] = mk(6'(scl_pkg::KIND_SINGLE_BASE + int'(si)), scl_pkg::ERR_NONE,
						tok_line_q, tok_col_q, scl_pkg::len_t'(1));
					n = 2'd1;
					fresh = 1'b1;
				end
			end
			M_IDENT: begin
				if (scl_pkg::is_letter(c) || scl_pkg::is_digit(c) || c == "_") begin
					len_d = grown;
					if (scl_pkg::is_letter(c)) letter_d = 1'b1;
				end else begin
					fin = 1'b1;
					fresh = 1'b1;
				end
			end
			M_ZERO, M_DEC: begin
				if (mode_q == M_ZERO && c == "x") begin
					len_d = grown;
					mode_d = M_HEX;
					hexdig_d = 1'b0;
				end else if (scl_pkg::is_letter(c) || scl_pkg::is_digit(c) || c == "_"
						|| c == ".") begin
					len_d = grown;
					mode_d = M_DEC;
				end else begin
					it[0] = mk(6'd0, scl_pkg::ERR_DECIMAL, tok_line_q, tok_col_q, len_q);
					n = 2'd1;
					fresh = 1'b1;
				end
			end
			M_HEX: begin
				if (scl_pkg::is_hex(c)) begin
					len_d = grown;
					hexdig_d = 1'b1;
				end else if (c == "_" && hexdig_q) begin
					len_d = grown;
				end else if (c == "_") begin
					it[0] = mk(scl_pkg::KIND_HEX, scl_pkg::ERR_NONE, tok_line_q, tok_col_q, len_q);
					it[1] = mk(6'd0, scl_pkg::ERR_HEX_UNDERSCORE, line_q, col_q,
						scl_pkg::len_t'(1));
					n = 2'd2;
					mode_d = M_IDLE;
				end else begin
					it[0] = mk(scl_pkg::KIND_HEX, scl_pkg::ERR_NONE, tok_line_q, tok_col_q, len_q);
					n = 2'd1;
					fresh = 1'b1;
				end
			end
			M_LINE_CMT: if (c == 8'd10) mode_d = M_IDLE;
			M_BLOCK_CMT: begin
				if (star_q && c == "/") begin
					mode_d = M_IDLE;
					star_d = 1'b0;
				end else star_d = c == "*";
			end
			default: fresh = 1'b1;
		endcase
		if (fin) begin
			if (letter_q) it[0] = mk(scl_pkg::KIND_IDENT, scl_pkg::ERR_NONE, tok_line_q,
				tok_col_q, len_q);
			else it[0] = mk(6'd0, scl_pkg::ERR_NO_LETTER, tok_line_q, tok_col_q, len_q);
			n = 2'd1;
		end
		if (fresh) begin
			mode_d = M_IDLE;
			if (!scl_pkg::is_space(c)) begin
				tok_line_d = line_q;
				tok_col_d = col_q;
				len_d = scl_pkg::len_t'(1);
				if (scl_pkg::single_index(c) != scl_pkg::SYM_NONE) begin
					mode_d = M_SYM;
					held_d = c;
				end else if (scl_pkg::is_letter(c) || c == "_") begin
					mode_d = M_IDENT;
					letter_d = scl_pkg::is_letter(c);
				end else if (c == "0") mode_d = M_ZERO;
				else if (scl_pkg::is_digit(c)) mode_d = M_DEC;
				else begin
					tok_line_d = tok_line_q;
					tok_col_d = tok_col_q;
					len_d = len_q;
					it[n] = mk(6'd0, scl_pkg::ERR_BAD_CHAR, line_q, col_q, scl_pkg::len_t'(1));
					n = n + 2'd1;
				end
			end
		end
		if (c == 8'd10) begin
			line_d = (&line_q) ? line_q : line_q + 1'b1;
			col_d = '0;
		end else begin
			line_d = line_q;
			col_d = (&col_q) ? col_q : col_q + 1'b1;
		end
		if (in_item.end_of_text) begin
			case (mode_d)
				M_SYM: begin
					it[n] = mk(6'(scl_pkg::KIND_SINGLE_BASE
						+ int'(scl_pkg::single_index(held_d))), scl_pkg::ERR_NONE,
						tok_line_d, tok_col_d, scl_pkg::len_t'(1));
					n = n + 2'd1;
				end
				M_IDENT: begin
					it[n] = letter_d
						? mk(scl_pkg::KIND_IDENT, scl_pkg::ERR_NONE, tok_line_d, tok_col_d, len_d)
						: mk(6'd0, scl_pkg::ERR_NO_LETTER, tok_line_d, tok_col_d, len_d);
					n = n + 2'd1;
				end
				M_ZERO, M_DEC: begin
					it[n] = mk(6'd0, scl_pkg::ERR_DECIMAL, tok_line_d, tok_col_d, len_d);
					n = n + 2'd1;
				end
				M_HEX: begin
					it[n] = mk(scl_pkg::KIND_HEX, scl_pkg::ERR_NONE, tok_line_d, tok_col_d, len_d);
					n = n + 2'd1;
				end
				M_BLOCK_CMT: begin
					it[n] = mk(6'd0, scl_pkg::ERR_OPEN_COMMENT, tok_line_d, tok_col_d, '0);
					n = n + 2'd1;
				end
				default: ;
			endcase
			it[n] = mk(scl_pkg::KIND_END, scl_pkg::ERR_NONE, line_d, col_d, '0);
			n = n + 2'd1;
			mode_d = M_IDLE;
			held_d = '0;
			line_d = scl_pkg::line_t'(1);
			col_d = '0;
			tok_line_d = '0;
			tok_col_d = '0;
			len_d = '0;
			letter_d = 1'b0;
			hexdig_d = 1'b0;
			star_d = 1'b0;
		end
		if (n != 2'd0) it[n-2'd1].last_of_run = 1'b1;
		items = it;
		item_count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			held_q <= '0;
			line_q <= scl_pkg::line_t'(1);
			col_q <= '0;
			tok_line_q <= '0;
			tok_col_q <= '0;
			len_q <= '0;
			letter_q <= 1'b0;
			hexdig_q <= 1'b0;
			star_q <= 1'b0;
		end else if (in_fire) begin
			mode_q <= mode_d;
			held_q <= held_d;
			line_q <= line_d;
			col_q <= col_d;
			tok_line_q <= tok_line_d;
			tok_col_q <= tok_col_d;
			len_q <= len_d;
			letter_q <= letter_d;
			hexdig_q <= hexdig_d;
			star_q <= star_d;
		end
	end

	// end of text always leaves the scanner back at its start position
	a_eot_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_item.end_of_text |=> mode_q == M_IDLE && col_q == '0)
		else $error("scanner not restarted after end of text");

endmodule

// ===== design/scl_queue.sv =====
// scl_queue: result FIFO between scanner and output port; writes up to three
// items per cycle, reads one. Uses scl_pkg.
module scl_queue #(
	parameter int DEPTH_LOG = 3
) (
	input logic clk,
	input logic arst_n,
	input scl_pkg::out_item_t [2:0] wr_items,
	input logic [1:0] wr_count,
	output logic room,
	output scl_pkg::out_item_t rd_item,
	output logic rd_valid,
	input logic rd_ready
);

	localparam int DEPTH = 1 << DEPTH_LOG;

	scl_pkg::out_item_t mem_q [DEPTH];
	logic [DEPTH_LOG-1:0] wp_q, rp_q;
	logic [DEPTH_LOG:0] cnt_q;
	logic pop;

	assign rd_valid = cnt_q != '0;
	assign rd_item = mem_q[rp_q];
	assign pop = rd_valid && rd_ready;
	assign room = cnt_q <= (DEPTH_LOG+1)'(DEPTH - 3);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			if (i < int'(wr_count)) mem_q[wp_q + DEPTH_LOG'(i)] <= wr_items[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + DEPTH_LOG'(wr_count);
			rp_q <= rp_q + DEPTH_LOG'(pop);
			cnt_q <= cnt_q + (DEPTH_LOG+1)'(wr_count) - (DEPTH_LOG+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (DEPTH_LOG+1)'(DEPTH))
		else $error("queue overflow");

	a_room_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_count == 2'd0 || room)
		else $error("write without room");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for source_code_lexer.
// Depends on design/scl_pkg.sv and design/source_code_lexer.sv.
module tb_top;

	localparam int SCAN_IDLE = 0;
	localparam int SCAN_SYM = 1;
	localparam int SCAN_IDENT = 2;
	localparam int SCAN_ZERO = 3;
	localparam int SCAN_HEX = 4;
	localparam int SCAN_DEC = 5;
	localparam int SCAN_LINE_CMT = 6;
	localparam int SCAN_BLOCK_CMT = 7;
	localparam int NUM_RANDOM = 260;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	scl_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	scl_pkg::out_item_t out_data;

	int errors = 0;
	bit stim_done = 0;
	bit hold_off = 0;
	scl_pkg::out_item_t token_q[$];

	always #6 clk = ~clk;

	source_code_lexer i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// ---------------------------------------------------------------
	// Lexer predictor: own copy of scanner state
	// ---------------------------------------------------------------
	int lx_mode;
	logic [7:0] lx_held;
	logic [19:0] lx_line;
	logic [15:0] lx_col;
	logic [19:0] lx_tok_line;
	logic [15:0] lx_tok_col;
	logic [15:0] lx_tok_len;
	bit lx_letter, lx_hexdig, lx_star;
	scl_pkg::out_item_t lx_out[$];

	function automatic int sym_of(logic [7:0] c);
		string s;
		s = "<>;:+-*,=#!/%(){}.[]&|^?$";
		for (int i = 0; i < 25; i++)
			if (s[i] == c) return i;
		return -1;
	endfunction

	function automatic int op_of(logic [7:0] a, logic [7:0] b);
		string f, s;
		f = "<>!=<>&|-+-+*-/&|^%";
		s = "====<>&|>+-========";
		for (int i = 0; i < 19; i++)
			if (f[i] == a && s[i] == b) return i;
		return -1;
	endfunction

	function automatic bit ch_letter(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction
	function automatic bit ch_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic bit ch_hex(logic [7:0] c);
		return ch_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction
	function automatic bit ch_space(logic [7:0] c);
		return c == 32 || c == 10 || c == 13 || c == 9 || c == 8 || c == 11 || c == 12;
	endfunction

	task automatic lx_push(int kind, logic [2:0] code, logic [19:0] ln,
			logic [15:0] col, logic [15:0] len);
		scl_pkg::out_item_t o;
		o.token_kind = 6'(kind);
		o.is_error = code != scl_pkg::ERR_NONE;
		o.error_code = code;
		o.start_line = ln;
		o.start_column = col;
		o.token_length = len;
		o.last_of_run = 1'b0;
		if (lx_out.size() < 3) lx_out.insert(lx_out.size(), o);
	endtask

	task automatic lx_clear();
		lx_mode = SCAN_IDLE; lx_held = '0; lx_line = 20'd1; lx_col = '0;
		lx_tok_line = '0; lx_tok_col = '0; lx_tok_len = '0;
		lx_letter = 0; lx_hexdig = 0; lx_star = 0;
	endtask

	task automatic lx_begin(int m, logic [19:0] ln, logic [15:0] col);
		lx_mode = m; lx_tok_line = ln; lx_tok_col = col; lx_tok_len = 16'd1;
	endtask

	task automatic lx_grow();
		if (lx_tok_len != 16'hFFFF) lx_tok_len++;
	endtask

	task automatic lx_fresh(logic [7:0] c, logic [19:0] ln, logic [15:0] col);
		lx_mode = SCAN_IDLE;
		if (ch_space(c)) return;
		if (sym_of(c) >= 0) begin
			lx_begin(SCAN_SYM, ln, col); lx_held = c;
		end else if (ch_letter(c) || c == "_") begin
			lx_begin(SCAN_IDENT, ln, col); lx_letter = ch_letter(c);
		end else if (c == "0") lx_begin(SCAN_ZERO, ln, col);
		else if (ch_digit(c)) lx_begin(SCAN_DEC, ln, col);
		else lx_push(0, scl_pkg::ERR_BAD_CHAR, ln, col, 16'd1);
	endtask

	task automatic lx_finish();
		case (lx_mode)
			SCAN_SYM: if (sym_of(lx_held) >= 0)
				lx_push(scl_pkg::KIND_SINGLE_BASE + sym_of(lx_held), scl_pkg::ERR_NONE,
					lx_tok_line, lx_tok_col, 16'd1);
			SCAN_IDENT: if (lx_letter)
					lx_push(scl_pkg::KIND_IDENT, scl_pkg::ERR_NONE, lx_tok_line, lx_tok_col,
						lx_tok_len);
				else lx_push(0, scl_pkg::ERR_NO_LETTER, lx_tok_line, lx_tok_col, lx_tok_len);
			SCAN_ZERO, SCAN_DEC:
				lx_push(0, scl_pkg::ERR_DECIMAL, lx_tok_line, lx_tok_col, lx_tok_len);
			SCAN_HEX:
				lx_push(scl_pkg::KIND_HEX, scl_pkg::ERR_NONE, lx_tok_line, lx_tok_col, lx_tok_len);
			SCAN_BLOCK_CMT:
				lx_push(0, scl_pkg::ERR_OPEN_COMMENT, lx_tok_line, lx_tok_col, 16'd0);
			default: ;
		endcase
		lx_mode = SCAN_IDLE;
	endtask

	task automatic lx_scan(logic [7:0] c, logic [19:0] ln, logic [15:0] col);
		case (lx_mode)
			SCAN_SYM: begin
				if (lx_held == "/" && c == "/") lx_mode = SCAN_LINE_CMT;
				else if (lx_held == "/" && c == "*") begin
					lx_mode = SCAN_BLOCK_CMT; lx_star = 0;
				end else if (op_of(lx_held, c) >= 0) begin
					lx_push(op_of(lx_held, c), scl_pkg::ERR_NONE, lx_tok_line, lx_tok_col, 16'd2);
					lx_mode = SCAN_IDLE;
				end else begin
					lx_finish(); lx_fresh(c, ln, col);
				end
			end
			SCAN_IDENT: begin
				if (ch_letter(c) || ch_digit(c) || c == "_") begin
					lx_grow(); if (ch_letter(c)) lx_letter = 1;
				end else begin
					lx_finish(); lx_fresh(c, ln, col);
				end
			end
			SCAN_ZERO, SCAN_DEC: begin
				if (lx_mode == SCAN_ZERO && c == "x") begin
					lx_grow(); lx_mode = SCAN_HEX; lx_hexdig = 0;
				end else begin
					lx_mode = SCAN_DEC;
					if (ch_letter(c) || ch_digit(c) || c == "_" || c == ".") lx_grow();
					else begin
						lx_finish(); lx_fresh(c, ln, col);
					end
				end
			end
			SCAN_HEX: begin
				if (ch_hex(c)) begin
					lx_grow(); lx_hexdig = 1;
				end else if (c == "_") begin
					if (lx_hexdig) lx_grow();
					else begin
						lx_finish(); lx_push(0, scl_pkg::ERR_HEX_UNDERSCORE, ln, col, 16'd1);
					end
				end else begin
					lx_finish(); lx_fresh(c, ln, col);
				end
			end
			SCAN_LINE_CMT: if (c == 10) lx_mode = SCAN_IDLE;
			SCAN_BLOCK_CMT: begin
				if (lx_star && c == "/") begin
					lx_mode = SCAN_IDLE; lx_star = 0;
				end else lx_star = c == "*";
			end
			default: lx_fresh(c, ln, col);
		endcase
	endtask

	// One byte in; results appended to token_q
	task automatic lx_predict(scl_pkg::in_item_t it);
		logic [19:0] ln;
		logic [15:0] col;
		ln = lx_line; col = lx_col;
		lx_out.delete();
		lx_scan(it.char_code, ln, col);
		if (it.char_code == 10) begin
			if (lx_line != 20'hFFFFF) lx_line++;
			lx_col = 0;
		end else if (lx_col != 16'hFFFF) lx_col++;
		if (it.end_of_text) begin
			lx_finish();
			lx_push(scl_pkg::KIND_END, scl_pkg::ERR_NONE, lx_line, lx_col, 16'd0);
			lx_clear();
		end
		if (lx_out.size() > 0) lx_out[lx_out.size() - 1].last_of_run = 1'b1;
		foreach (lx_out[i]) token_q.insert(token_q.size(), lx_out[i]);
	endtask

	// ---------------------------------------------------------------
	// Sender: bursts and gaps
	// ---------------------------------------------------------------
	task automatic send_byte(logic [7:0] c, bit eot);
		scl_pkg::in_item_t it;
		it.char_code = c;
		it.end_of_text = eot;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		lx_predict(it);
	endtask

	int burst_left = 0;
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
	endtask

	task automatic send_text(string s, bit eot);
		for (int i = 0; i < s.len(); i++) begin
			pace();
			send_byte(s[i], eot && i == s.len() - 1);
		end
	endtask

	// Random well-formed fragments with random content, some noise
	function automatic string rnd_frag();
		string s, al, hx, sy;
		int n;
		al = "abcXYZ_019q"; hx = "0123456789abcdefABCDEF_"; sy = "<>;:+-*,=#!/%(){}.[]&|^?$";
		s = "";
		case ($urandom_range(0, 9))
			0: begin n = $urandom_range(1, 5); s = "a";
				repeat (n) s = {s, string'(al[$urandom_range(0, al.len() - 1)])}; end
			1: begin s = "0x"; repeat ($urandom_range(0, 5))
				s = {s, string'(hx[$urandom_range(0, hx.len() - 1)])}; end
			2: begin s = {string'(sy[$urandom_range(0, 24)]), string'(sy[$urandom_range(0, 24)])}; end
			3: s = {string'(sy[$urandom_range(0, 24)]), "="};
			4: s = "/* x * y **/";
			5: s = "// c\n";
			6: s = {string'(8'($urandom_range(1, 255)))};
			7: s = "12.5_k";
			8: s = "__1";
			default: s = {string'(8'($urandom_range(0, 2) == 0 ? 10 : 32))};
		endcase
		return s;
	endfunction

	// Directed table: byte text, end flag, typed expectation when obvious
	typedef struct {
		string text;
		bit eot;
		bit typed;
		scl_pkg::out_item_t want;
	} dir_row_t;
	dir_row_t dir_rows[$];

	function automatic scl_pkg::out_item_t mk(logic [5:0] k, logic [2:0] e, logic [19:0] l,
			logic [15:0] c, logic [15:0] n, bit last);
		scl_pkg::out_item_t o;
		o = '{k, e != scl_pkg::ERR_NONE, e, l, c, n, last};
		return o;
	endfunction

	task automatic add_row(string t, bit eot, bit typed, scl_pkg::out_item_t w);
		dir_row_t r;
		r.text = t; r.eot = eot; r.typed = typed; r.want = w;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	// ---------------------------------------------------------------
	// Main stimulus
	// ---------------------------------------------------------------
	initial begin
		string s;
		int base;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		lx_clear();
		// single byte at reset position: end token just past it
		add_row(" ", 1'b1, 1'b1, mk(scl_pkg::KIND_END, scl_pkg::ERR_NONE, 20'd1, 16'd1, 16'd0,
			1'b1));
		add_row({string'(8'd255)}, 1'b0, 1'b1, mk(6'd0, scl_pkg::ERR_BAD_CHAR, 20'd1, 16'd0,
			16'd1, 1'b1));
		add_row({string'(8'd127)}, 1'b1, 1'b0, '0);
		add_row("<= >= != == << >> && || -> ++ -- += *= -= /= &= |= ^= %= ", 1'b0, 1'b0, '0);
		add_row("< > ; : + - * , = # ! / % ( ) { } . [ ] & | ^ ? $ ", 1'b0, 1'b0, '0);
		add_row("abc _1 __ 0x1F_a 0xAbC 0x_ 0xG 123 0.5z ", 1'b0, 1'b0, '0);
		add_row("// line\nx /* a */ y /*/ z */ /**/", 1'b0, 1'b0, '0);
		add_row("a\tb\r\n@~\\", 1'b0, 1'b0, '0);
		add_row("/* open", 1'b1, 1'b0, '0);
		add_row("// open", 1'b1, 1'b0, '0);
		add_row("0x", 1'b1, 1'b0, '0);
		add_row("q", 1'b1, 1'b0, '0);
		foreach (dir_rows[i]) begin
			base = token_q.size();
			send_text(dir_rows[i].text, dir_rows[i].eot);
			if (dir_rows[i].typed && (token_q.size() != base + 1
					|| token_q[base] != dir_rows[i].want)) begin
				$error("directed row %0d: typed token %p differs from prediction", i,
					dir_rows[i].want);
				errors++;
			end
		end
		// NUL byte cannot travel inside a string
		pace();
		send_byte(8'd0, 1'b0);
		// random: mostly well-formed fragments, end marks now and then
		for (int n = 0; n < NUM_RANDOM; ) begin
			s = rnd_frag();
			if (n > 150 && n < 170) hold_off = 1;
			send_text(s, $urandom_range(0, 15) == 0);
			n += s.len();
		end
		send_text("z", 1'b1);
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// Receiver: stall pattern, plus long hold-offs while the sender runs on
	initial begin
		int pat;
		pat = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (150) @(posedge clk);
				hold_off = 0;
			end
			pat++;
			out_ready <= (pat % 7 < 4) || (pat % 64 > 40) ? 1'b1 : ($urandom_range(0, 1) == 1);
		end
	end

	// Checker: every accepted result against the oldest prediction
	always @(posedge clk) begin
		scl_pkg::out_item_t w;
		if (arst_n && out_valid && out_ready) begin
			if (token_q.size() == 0) begin
				$error("unexpected token %p", out_data);
				errors++;
			end else begin
				w = token_q.pop_front();
				if (out_data.token_kind !== w.token_kind) begin
					$error("token_kind exp %0d got %0d", w.token_kind, out_data.token_kind); errors++; end
				if (out_data.is_error !== w.is_error) begin
					$error("is_error exp %0d got %0d", w.is_error, out_data.is_error); errors++; end
				if (out_data.error_code !== w.error_code) begin
					$error("error_code exp %0d got %0d", w.error_code, out_data.error_code); errors++; end
				if (out_data.start_line !== w.start_line) begin
					$error("start_line exp %0d got %0d", w.start_line, out_data.start_line); errors++; end
				if (out_data.start_column !== w.start_column) begin
					$error("start_column exp %0d got %0d", w.start_column, out_data.start_column);
					errors++; end
				if (out_data.token_length !== w.token_length) begin
					$error("token_length exp %0d got %0d", w.token_length, out_data.token_length);
					errors++; end
				if (out_data.last_of_run !== w.last_of_run) begin
					$error("last_of_run exp %0d got %0d", w.last_of_run, out_data.last_of_run); errors++; end
			end
		end
	end

	// End of run: drain, then a short tail
	initial begin
		wait (stim_done);
		wait (token_q.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && token_q.size() == 0)
			$display("source_code_lexer: match");
		else
			$display("source_code_lexer: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("source_code_lexer: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
design/scl_pkg.sv
design/scl_front.sv
design/scl_queue.sv
design/source_code_lexer.sv
tb/tb_top.sv
